// ===== hdl/dtsd_pkg.sv =====
// Shared constants, types and a helper function of the distance-to-stock debouncer.
`default_nettype none

package dtsd_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CMP_W   = 6;
  localparam int DIST_W     = 16;
  localparam int COUNT_W    = 7;
  localparam int DEPTH_W    = 10;
  localparam int OFFS_W     = 12;
  localparam int LIMIT_W    = 18;
  localparam int CMP_W      = 19;
  localparam int NUM_W      = 15;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int MATCH_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MATCH_W-1:0] MATCHES_TO_PUBLISH = 2'd3;

  localparam logic [COUNT_W-1:0] RST_FULL_STOCK = 7'd10;
  localparam logic [DEPTH_W-1:0] RST_ITEM_DEPTH = 10'd64;
  localparam logic [OFFS_W-1:0]  RST_BASE_OFFSET = 12'd0;
  localparam logic [OFFS_W-1:0]  RST_NEAR_OFFSET = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTING_ENABLED = 3'd0,
    REG_FULL_STOCK       = 3'd1,
    REG_ITEM_DEPTH       = 3'd2,
    REG_BASE_OFFSET      = 3'd3,
    REG_NEAR_OFFSET      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                counting_enabled;
    logic [COUNT_W-1:0]  full_stock;
    logic [DEPTH_W-1:0]  item_depth;
    logic [OFFS_W-1:0]   base_offset;
    logic [OFFS_W-1:0]   near_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    KIND_OUTSIDE = 3'd0,
    KIND_HOLD    = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_DIVIDE  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    kind_t            kind;
    logic [NUM_W-1:0] numer;
  } job_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
    logic              empty;
  } queue_status_t;

  // A depth of zero is treated as one millimeter.
  function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] depth);
    eff_depth = (depth == '0) ? DEPTH_W'(1) : depth;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dtsd_ifs.sv =====
// Valid/ready channel interfaces for the sample input and the stock result output.
`default_nettype none

interface dtsd_in_if import dtsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel;
  logic signed [DIST_W-1:0] distance_mm;
  logic                     range_valid;

  modport source (output valid, output channel, output distance_mm, output range_valid,
                  input ready);
  modport sink (input valid, input channel, input distance_mm, input range_valid,
                output ready);
endinterface

interface dtsd_out_if import dtsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] stock_count;
  logic               newly_published;

  modport source (output valid, output stock_count, output newly_published, input ready);
  modport sink (input valid, input stock_count, input newly_published, output ready);
endinterface

`default_nettype wire

// ===== hdl/distance_to_stock_debouncer.sv =====
// Top level of the distance-to-stock debouncer with its configuration registers.
//
// Each word on in_chan is one ranging sample (channel, signed distance in mm,
// range_valid). Every accepted word yields exactly one word on out_chan: the
// published stock count of that channel after the sample, and newly_published
// when the sample was the third consecutive match that published a new count.
// A front end classifies each sample and writes a job into a two-entry queue;
// the back end turns the distance into a count with a restoring divider that
// produces one quotient bit per cycle, then updates the channel. The back end
// works on one job at a time; in_chan.ready stays high while the queue has
// room, so new samples are taken while a division is still running.
// When the receiver stalls, the result waits in the output register, the back
// end holds its finished job, and the queue fills before in_chan.ready drops.
// Synchronous reset clears all channel state, the queue and the output, and
// loads the register defaults. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while no word is in
// flight, as the block itself does not enforce this.
`default_nettype none

module distance_to_stock_debouncer import dtsd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  dtsd_in_if.sink                    in_chan,
  dtsd_out_if.source                 out_chan
);

  cfg_t          cfg_r, cfg_nxt;
  job_t          wr_job, rd_job;
  logic          push, pop;
  queue_status_t q_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COUNTING_ENABLED: cfg_nxt.counting_enabled = cfg_data[0];
        REG_FULL_STOCK:       cfg_nxt.full_stock       = cfg_data[COUNT_W-1:0];
        REG_ITEM_DEPTH:       cfg_nxt.item_depth       = cfg_data[DEPTH_W-1:0];
        REG_BASE_OFFSET:      cfg_nxt.base_offset      = cfg_data[OFFS_W-1:0];
        REG_NEAR_OFFSET:      cfg_nxt.near_offset      = cfg_data[OFFS_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counting_enabled <= 1'b1;
      cfg_r.full_stock       <= RST_FULL_STOCK;
      cfg_r.item_depth       <= RST_ITEM_DEPTH;
      cfg_r.base_offset      <= RST_BASE_OFFSET;
      cfg_r.near_offset      <= RST_NEAR_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dtsd_front u_front (
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .queue_full (q_stat.full),
    .push       (push),
    .job        (wr_job)
  );

  dtsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .status (q_stat)
  );

  dtsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .queue_empty (q_stat.empty),
    .rd_job      (rd_job),
    .pop         (pop),
    .out_chan    (out_chan)
  );

  a_fresh_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.newly_published) |-> (out_chan.stock_count <= cfg_r.full_stock))
    else $error("Newly published count exceeds the full stock.");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("Back end took a job from an empty queue.");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QLVL_W'(QUEUE_DEPTH))
    else $error("Queue level beyond its depth.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_stat.level == $past(q_stat.level) + 1'b1))
    else $error("Queue level did not follow a push.");

endmodule

`default_nettype wire

// ===== hdl/dtsd_queue.sv =====
// Two-entry job queue between the classifying front end and the back end.
`default_nettype none

module dtsd_queue import dtsd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire job_t          wr_job,
  input  wire logic          pop,
  output job_t               rd_job,
  output queue_status_t      status
);

  job_t                entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0]   level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job       = entries_r[rd_ptr_r];
  assign status.level = level_r;
  assign status.full  = (level_r == QLVL_W'(QUEUE_DEPTH));
  assign status.empty = (level_r == '0);

endmodule

`default_nettype wire

// ===== hdl/dtsd_front.sv =====
// Front end: accepts samples and sorts them into full, empty, divide, no-change or outside-channel jobs.
`default_nettype none

module dtsd_front import dtsd_pkg::*; (
  input  wire cfg_t  cfg,
  dtsd_in_if.sink    in_chan,
  input  wire logic  queue_full,
  output logic       push,
  output job_t       job
);

  logic [LIMIT_W-1:0]      empty_limit;
  logic signed [CMP_W-1:0] dist_s, near_s, base_s, limit_s, diff_s;
  logic                    chan_ok;

  assign empty_limit = LIMIT_W'(cfg.full_stock) * LIMIT_W'(eff_depth(cfg.item_depth))
                     + LIMIT_W'(cfg.base_offset);

  assign dist_s  = CMP_W'(in_chan.distance_mm);
  assign near_s  = $signed({{(CMP_W - OFFS_W){1'b0}}, cfg.near_offset});
  assign base_s  = $signed({{(CMP_W - OFFS_W){1'b0}}, cfg.base_offset});
  assign limit_s = $signed({{(CMP_W - LIMIT_W){1'b0}}, empty_limit});
  assign diff_s  = dist_s - base_s;
  assign chan_ok = (CH_CMP_W'(in_chan.channel) < CH_CMP_W'(CHANNELS));

  always_comb begin
    job.channel = in_chan.channel;
    job.numer   = diff_s[NUM_W-1:0];
    if (!chan_ok) begin
      job.kind = KIND_OUTSIDE;
    end else if (!(in_chan.range_valid && cfg.counting_enabled)) begin
      job.kind = KIND_HOLD;
    end else if (dist_s < near_s) begin
      job.kind = KIND_FULL;
    end else if (dist_s > limit_s) begin
      job.kind = KIND_EMPTY;
    end else if (dist_s < base_s) begin
      job.kind = KIND_FULL;
    end else begin
      job.kind = KIND_DIVIDE;
    end
  end

  assign in_chan.ready = !queue_full;
  assign push          = in_chan.valid && !queue_full;

endmodule

`default_nettype wire

// ===== hdl/dtsd_back.sv =====
// Back end: serial divider, per-channel match debouncing and the output register.
`default_nettype none

module dtsd_back import dtsd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  queue_empty,
  input  wire job_t  rd_job,
  output logic       pop,
  dtsd_out_if.source out_chan
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [CH_W-1:0]     chan_r, chan_nxt;
  logic [DEPTH_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [COUNT_W-1:0]  cand_r [CHANNELS];
  logic [COUNT_W-1:0]  cand_nxt [CHANNELS];
  logic [MATCH_W-1:0]  match_r [CHANNELS];
  logic [MATCH_W-1:0]  match_nxt [CHANNELS];
  logic [COUNT_W-1:0]  pub_r [CHANNELS];
  logic [COUNT_W-1:0]  pub_nxt [CHANNELS];
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_fresh_r, out_fresh_nxt;

  logic [DEPTH_W:0]    trial, depth_ext;
  logic [COUNT_W-1:0]  cnt;
  logic [MATCH_W-1:0]  match_inc;
  logic [CH_IDX_W-1:0] idx;

  assign idx       = CH_IDX_W'(chan_r);
  assign depth_ext = {1'b0, eff_depth(cfg.item_depth)};
  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign match_inc = match_r[idx] + 1'b1;

  always_comb begin
    case (kind_r)
      KIND_FULL:   cnt = cfg.full_stock;
      KIND_DIVIDE: cnt = (quo_r > NUM_W'(cfg.full_stock)) ? '0
                         : cfg.full_stock - quo_r[COUNT_W-1:0];
      default:     cnt = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    chan_nxt      = chan_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    cand_nxt      = cand_r;
    match_nxt     = match_r;
    pub_nxt       = pub_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_fresh_nxt = out_fresh_r;
    pop           = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!queue_empty) begin
          pop       = 1'b1;
          kind_nxt  = rd_job.kind;
          chan_nxt  = rd_job.channel;
          quo_nxt   = rd_job.numer;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = (rd_job.kind == KIND_DIVIDE) ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (trial >= depth_ext) begin
          rem_nxt = DEPTH_W'(trial - depth_ext);
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DEPTH_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_fresh_nxt = 1'b0;
          state_nxt     = ST_IDLE;
          case (kind_r)
            KIND_OUTSIDE: begin
              out_count_nxt = '0;
            end
            KIND_HOLD: begin
              out_count_nxt = pub_r[idx];
            end
            default: begin
              out_count_nxt = pub_r[idx];
              if (cand_r[idx] == cnt) begin
                if (match_inc == MATCHES_TO_PUBLISH) begin
                  pub_nxt[idx]   = cnt;
                  match_nxt[idx] = '0;
                  out_fresh_nxt  = 1'b1;
                  out_count_nxt  = cnt;
                end else begin
                  match_nxt[idx] = match_inc;
                end
              end else begin
                cand_nxt[idx]  = cnt;
                match_nxt[idx] = '0;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cand_r      <= '{default: '0};
      match_r     <= '{default: '0};
      pub_r       <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cand_r      <= cand_nxt;
      match_r     <= match_nxt;
      pub_r       <= pub_nxt;
    end
    kind_r      <= kind_nxt;
    chan_r      <= chan_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    out_count_r <= out_count_nxt;
    out_fresh_r <= out_fresh_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.stock_count     = out_count_r;
  assign out_chan.newly_published = out_fresh_r;

endmodule

`default_nettype wire
